/* rtl/fftm_pkg.sv */
// Shared types, constants and twiddle tables for the FFT magnitude block.
package fftm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int BIN_W    = 6;
  localparam int MAG_W    = 12;
  localparam int TW_W     = 16;
  localparam logic [MAG_W-1:0] MAG_MAX = 12'd3000;

  // Quarter-wave cosine in Q15
  function automatic logic signed [TW_W-1:0] quarter_cos(input logic [4:0] j);
    logic signed [TW_W-1:0] v;
    begin
      unique case (j)
        5'd0:  v = 16'sd32767;
        5'd1:  v = 16'sd32610;
        5'd2:  v = 16'sd32138;
        5'd3:  v = 16'sd31357;
        5'd4:  v = 16'sd30274;
        5'd5:  v = 16'sd28899;
        5'd6:  v = 16'sd27246;
        5'd7:  v = 16'sd25330;
        5'd8:  v = 16'sd23170;
        5'd9:  v = 16'sd20788;
        5'd10: v = 16'sd18205;
        5'd11: v = 16'sd15447;
        5'd12: v = 16'sd12540;
        5'd13: v = 16'sd9512;
        5'd14: v = 16'sd6393;
        5'd15: v = 16'sd3212;
        default: v = 16'sd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [TW_W-1:0] tw_cos(input logic [4:0] j);
    begin
      if (j <= 5'd16) return quarter_cos(j);
      return -quarter_cos(5'd0 - j);
    end
  endfunction

  function automatic logic signed [TW_W-1:0] tw_sin(input logic [4:0] j);
    begin
      if (j <= 5'd16) return quarter_cos(5'd16 - j);
      return quarter_cos(j - 5'd16);
    end
  endfunction

  // Controller to datapath commands
  typedef enum logic [2:0] {
    OP_IDLE, OP_RD_B, OP_RD_A, OP_MUL, OP_WR, OP_MAG_RD, OP_MAG_SQ, OP_SQRT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [5:0] addr_a;
    logic [5:0] addr_b;
    logic [4:0] tw_idx;
    logic       wr_a;
    logic       wr_b;
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } dp_stat_t;

endpackage

/* rtl/fftm_stream_if.sv */
// Valid/ready stream interface with a generic payload.
interface fftm_stream_if #(parameter int W = 16) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/fftm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fftm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/fftm_datapath.sv */
// Store, butterfly unit, magnitude and square-root datapath.
module fftm_datapath #(
  parameter int SW   = 24,
  parameter int LOG2 = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fftm_pkg::dp_cmd_t      cmd,
  output fftm_pkg::dp_stat_t     stat,
  input  logic                   ld_we,
  input  logic [5:0]             ld_addr,
  input  logic [15:0]            ld_sample,
  output logic [11:0]            mag
);
  import fftm_pkg::*;

  localparam int FRAC = SW - 22;
  localparam int PW   = SW + TW_W + 1;
  localparam int SQW  = 2 * SW;
  localparam int RW   = SW;
  localparam int MSH  = FRAC + 15 + LOG2;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  logic [SW-1:0] re_rd, im_rd, re_wd, im_wd;
  logic [5:0]    waddr, raddr;
  logic          we;

  logic signed [SW-1:0] br_r, bi_r, ar_r, ai_r;
  logic signed [PW-1:0] pr_r, pi_r;
  logic signed [SW+1:0] sum_r_r, sum_i_r, dif_r_r, dif_i_r;
  logic                 wr_sel_r;
  logic [SQW-1:0]       sq_r;
  logic [SQW:0]         rem_r;
  logic [RW-1:0]        root_r;
  logic [$clog2(RW+1)-1:0] cnt_r;
  logic                 busy_r;
  logic                 stat_first_r;

  fftm_ram #(.WIDTH(SW), .DEPTH(64)) u_re (
    .clk(clk), .we(we), .waddr(waddr), .wdata(re_wd), .raddr(raddr), .rdata(re_rd));
  fftm_ram #(.WIDTH(SW), .DEPTH(64)) u_im (
    .clk(clk), .we(we), .waddr(waddr), .wdata(im_wd), .raddr(raddr), .rdata(im_rd));

  function automatic logic signed [SW-1:0] sat(input logic signed [SW+1:0] v);
    begin
      if (v > (SW+2)'(SMAX)) return SMAX;
      if (v < (SW+2)'(SMIN)) return SMIN;
      return v[SW-1:0];
    end
  endfunction

  // Read address: b then a during butterflies, a for readout
  always_comb begin
    raddr = (cmd.op == OP_RD_B) ? cmd.addr_b : cmd.addr_a;
  end

  // Write mux: load, or butterfly result to a then b
  always_comb begin
    we    = 1'b0;
    waddr = ld_addr;
    re_wd = {{(SW-SAMPLE_W){ld_sample[15]}}, ld_sample} << FRAC;
    im_wd = '0;
    if (ld_we) begin
      we = 1'b1;
    end else if (cmd.wr_a) begin
      we = 1'b1; waddr = cmd.addr_a;
      re_wd = sat(sum_r_r); im_wd = sat(sum_i_r);
    end else if (cmd.wr_b) begin
      we = 1'b1; waddr = cmd.addr_b;
      re_wd = sat(dif_r_r); im_wd = sat(dif_i_r);
    end
  end

  // Butterfly: capture b, capture a and form products, then add/sub
  logic signed [TW_W-1:0] wr, wi;
  logic signed [PW-1:0]   tr, ti;
  always_comb begin
    wr = tw_cos(cmd.tw_idx);
    wi = -tw_sin(cmd.tw_idx);
    tr = (pr_r + PW'(16384)) >>> 15;
    ti = (pi_r + PW'(16384)) >>> 15;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_RD_A: begin
        br_r <= re_rd; bi_r <= im_rd;
      end
      OP_MUL: begin
        ar_r <= re_rd; ai_r <= im_rd;
        pr_r <= PW'(wr * br_r) - PW'(wi * bi_r);
        pi_r <= PW'(wr * bi_r) + PW'(wi * br_r);
      end
      OP_WR: begin
        if (!cmd.wr_a) begin
          sum_r_r <= (SW+2)'(ar_r) + (SW+2)'(tr);
          sum_i_r <= (SW+2)'(ai_r) + (SW+2)'(ti);
          dif_r_r <= (SW+2)'(ar_r) - (SW+2)'(tr);
          dif_i_r <= (SW+2)'(ai_r) - (SW+2)'(ti);
        end
      end
      OP_MAG_SQ: begin
        br_r <= re_rd[SW-1] ? -re_rd : re_rd;
        bi_r <= im_rd[SW-1] ? -im_rd : im_rd;
      end
      default: ;
    endcase
  end

  // Square-root sequencing: load on the first cycle, then RW steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      cnt_r        <= '0;
      stat_first_r <= 1'b0;
    end else if (cmd.op == OP_MAG_RD) begin
      busy_r <= 1'b0;
    end else if (cmd.op == OP_MAG_SQ) begin
      busy_r       <= 1'b1;
      cnt_r        <= '0;
      stat_first_r <= 1'b0;
    end else if (cmd.op == OP_SQRT && busy_r) begin
      if (!stat_first_r) begin
        stat_first_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(RW+1))'(RW - 1)) busy_r <= 1'b0;
      end
    end
  end

  // Squares, then one bit of the restoring square root per cycle
  logic [SQW-1:0] sqsum;
  logic [SQW-1:0] sq_a, sq_b;
  always_comb begin
    sq_a  = SQW'(br_r[SW-1:0]) * SQW'(br_r[SW-1:0]);
    sq_b  = SQW'(bi_r[SW-1:0]) * SQW'(bi_r[SW-1:0]);
    sqsum = sq_a + sq_b;
  end

  logic [1:0] pair;
  logic [SQW+1:0] rem2;
  always_comb begin
    pair = sq_r[SQW-1:SQW-2];
    rem2 = {rem_r[SQW-1:0], pair};
  end

  logic [SQW+1:0] cand;
  always_comb cand = {{(SQW-RW){1'b0}}, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQRT && busy_r && !stat_first_r) begin
      sq_r   <= sqsum;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.op == OP_SQRT && busy_r) begin
      sq_r <= {sq_r[SQW-3:0], 2'b00};
      if (rem2 >= cand) begin
        rem_r  <= (SQW+1)'(rem2 - cand);
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= (SQW+1)'(rem2);
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  // Scale and saturate
  logic [RW+12-1:0] scaled;
  always_comb begin
    scaled = (RW+12)'(root_r) * (RW+12)'(3000);
    scaled = scaled >> MSH;
    mag    = (scaled > (RW+12)'(MAG_MAX)) ? MAG_MAX : scaled[MAG_W-1:0];
    stat.sqrt_done = (cmd.op == OP_SQRT) && !busy_r;
  end
endmodule

/* rtl/fftm_ctrl.sv */
// Sequencer for loading, butterfly passes and the magnitude readout.
module fftm_ctrl #(
  parameter int LOG2 = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  output logic               in_rdy,
  output logic [5:0]         ld_addr,
  output fftm_pkg::dp_cmd_t  cmd,
  input  fftm_pkg::dp_stat_t stat,
  output logic               res_load,
  input  logic               res_free,
  output logic [5:0]         res_bin,
  output logic               res_last
);
  import fftm_pkg::*;

  localparam int N = 1 << LOG2;

  typedef enum logic [3:0] {
    S_LOAD, S_RD_B, S_RD_A, S_MUL, S_WR_A, S_WR_B, S_WR_C, S_M_RD, S_M_SQ, S_SQRT, S_OUT
  } state_t;

  state_t     state_r;
  logic [6:0] cnt_r;
  logic [2:0] stage_r;
  logic [5:0] start_r, k_r, bin_r;

  logic [5:0] half, rev;
  logic [4:0] step_sh;
  always_comb begin
    half = 6'(1) << stage_r;
    rev  = '0;
    for (int i = 0; i < LOG2; i++) rev[LOG2-1-i] = cnt_r[i];
  end

  assign ld_addr  = rev;
  assign in_rdy   = (state_r == S_LOAD);
  assign res_bin  = bin_r;
  assign res_last = (bin_r == 6'(N - 1));

  always_comb begin
    cmd        = '0;
    cmd.addr_a = (state_r == S_M_RD || state_r == S_M_SQ ||
                  state_r == S_SQRT || state_r == S_OUT) ? bin_r : start_r + k_r;
    cmd.addr_b = start_r + k_r + half;
    step_sh    = 5'(k_r << (5 - stage_r));
    cmd.tw_idx = step_sh;
    unique case (state_r)
      S_RD_B: cmd.op = OP_RD_B;
      S_RD_A: cmd.op = OP_RD_A;
      S_MUL:  cmd.op = OP_MUL;
      // sums and differences, then a write, then b write
      S_WR_A: begin cmd.op = OP_WR; cmd.wr_a = 1'b0; end
      S_WR_B: begin cmd.op = OP_WR; cmd.wr_a = 1'b1; end
      S_WR_C: begin cmd.op = OP_IDLE; cmd.wr_b = 1'b1; end
      S_M_RD: cmd.op = OP_MAG_RD;
      S_M_SQ: cmd.op = OP_MAG_SQ;
      S_SQRT: cmd.op = OP_SQRT;
      default: cmd.op = OP_IDLE;
    endcase
  end

  assign res_load = (state_r == S_OUT) && res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; stage_r <= '0;
      start_r <= '0; k_r <= '0; bin_r <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: if (in_fire) begin
          if (cnt_r == 7'(N - 1)) begin
            cnt_r <= '0; stage_r <= '0; start_r <= '0; k_r <= '0;
            state_r <= S_RD_B;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_RD_B: state_r <= S_RD_A;
        S_RD_A: state_r <= S_MUL;
        S_MUL:  state_r <= S_WR_A;
        S_WR_A: state_r <= S_WR_B;
        S_WR_B: state_r <= S_WR_C;
        S_WR_C: begin
          state_r <= S_RD_B;
          if (k_r == half - 1'b1) begin
            k_r <= '0;
            if (7'(start_r) + 7'(2 * half) >= 7'(N)) begin
              start_r <= '0;
              if (stage_r == 3'(LOG2 - 1)) begin
                bin_r <= '0; state_r <= S_M_RD;
              end else stage_r <= stage_r + 1'b1;
            end else start_r <= start_r + 6'(2 * half);
          end else k_r <= k_r + 1'b1;
        end
        S_M_RD: state_r <= S_M_SQ;
        S_M_SQ: state_r <= S_SQRT;
        S_SQRT: if (stat.sqrt_done) state_r <= S_OUT;
        S_OUT: if (res_free) begin
          if (bin_r == 6'(N - 1)) state_r <= S_LOAD;
          else begin bin_r <= bin_r + 1'b1; state_r <= S_M_RD; end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

/* rtl/fft_magnitude_spectrum_top.sv */
// Flow: after the last sample, 192 butterflies run (read b, read a, multiply, add/sub,
// write a, write b); then each bin is read, squared, loaded into the 24-step restoring
// square root on one shared unit, finished and output, waiting while out stalls.
// A frame of 64 samples is loaded only after the previous frame's last bin is output;
// samples are taken one per cycle while loading, results wait in an output register.
// Reset: synchronous active-low rst_n clears the sequencer and sample count;
module fft_magnitude_spectrum_top #(
  parameter int FFT_POINTS  = 64,
  parameter int STORE_WIDTH = 24
) (
  input  logic clk,
  input  logic rst_n,
  fftm_stream_if.sink   in_s,
  fftm_stream_if.source out_s
);
  import fftm_pkg::*;

  localparam int LOG2 = (FFT_POINTS >= 64) ? 6 : (FFT_POINTS >= 32) ? 5 :
                        (FFT_POINTS >= 16) ? 4 : (FFT_POINTS >= 8) ? 3 :
                        (FFT_POINTS >= 4) ? 2 : (FFT_POINTS >= 2) ? 1 : 0;
  localparam int SW = (STORE_WIDTH < 22) ? 22 : (STORE_WIDTH > 32) ? 32 : STORE_WIDTH;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       in_rdy, res_load, res_last, valid_r;
  logic [5:0] ld_addr, res_bin;
  logic [11:0] mag;
  logic [18:0] out_r;

  assign in_s.ready = in_rdy;
  assign out_s.valid = valid_r;
  assign out_s.data  = out_r;

  fftm_ctrl #(.LOG2(LOG2)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_s.valid && in_rdy), .in_rdy(in_rdy),
    .ld_addr(ld_addr), .cmd(cmd), .stat(stat), .res_load(res_load),
    .res_free(!valid_r || out_s.ready), .res_bin(res_bin), .res_last(res_last));

  fftm_datapath #(.SW(SW), .LOG2(LOG2)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .ld_we(in_s.valid && in_rdy), .ld_addr(ld_addr), .ld_sample(in_s.data[15:0]),
    .mag(mag));

  // Output beat register: {last_bin, magnitude, bin_index}
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (res_load) valid_r <= 1'b1;
    else if (out_s.ready) valid_r <= 1'b0;
  end
  always_ff @(posedge clk) if (res_load) out_r <= {res_last, mag, res_bin};
endmodule
